FILE: rtl/srmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmd_pkg
// Shared types and constants of the side region mean difference block.
// ----------------------------------------------------------------------------
package srmd_pkg;

  localparam int unsigned DefMaxWidth  = 4096;
  localparam int unsigned DefMaxHeight = 4096;
  localparam int unsigned DefFracBits  = 4;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegPupilX  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPupilY  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPupilR  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIrisX   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIrisR   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWidth   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegHeight  = 3'd6;

  localparam int unsigned SumW = 32;
  localparam int unsigned CntW = 24;
  localparam int unsigned QuoW = 17;

  // frame totals handed from front to back
  typedef struct packed {
    logic [3:0][SumW-1:0] sums;
    logic [3:0][CntW-1:0] cnts;
    logic signed [16:0]   shift;
  } frame_t;

endpackage

FILE: rtl/side_region_mean_difference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// side_region_mean_difference
// Pupil side region mean difference per frame.
// ----------------------------------------------------------------------------
// Pixels enter on s_axis (tdata = pixel, tlast = end of frame), one per cycle.
// Geometry and image size must be written on cfg_* between frames (unchecked).
// The front classifies each pixel into four side rectangles and accumulates
// sums and counts at one pixel per cycle while its one-frame slot is empty.
// On tlast the totals move into that slot; unless a region is empty, the back
// runs four restoring divisions on one shared divider and then offers the
// result on m_axis. m_axis_tvalid rises once the back has taken the frame and
// finished the divisions, or straight after StDiv when a region is empty.
// The front keeps taking the next frame while the back works; while the slot
// holds a frame the back has not yet taken, s_axis_tready is low.
// A stalled receiver holds the result steady until taken.
// Reset clears counters and accumulators and restores width 640, height 480.
// ----------------------------------------------------------------------------
module side_region_mean_difference import srmd_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight,
  parameter int unsigned FracBits  = DefFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // pixel
  input  logic               s_axis_tlast,   // end_of_frame
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // eyelid_difference[16:0], horizontal_shift[33:17], status[34], zero pad
  output logic [39:0]        m_axis_tdata,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic [15:0] px_q, py_q, ix_q;
  logic [14:0] pr_q, ir_q;
  logic [12:0] w_q, h_q;
  logic frm_valid, frm_ready;
  frame_t frm;
  logic [34:0] res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; pr_q <= '0; ix_q <= '0; ir_q <= '0;
      w_q <= 13'd640; h_q <= 13'd480;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPupilX: px_q <= cfg_data_i;
        RegPupilY: py_q <= cfg_data_i;
        RegPupilR: pr_q <= cfg_data_i[14:0];
        RegIrisX:  ix_q <= cfg_data_i;
        RegIrisR:  ir_q <= cfg_data_i[14:0];
        RegWidth:  w_q  <= cfg_data_i[12:0];
        RegHeight: h_q  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  srmd_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight), .FracBits(FracBits))
  u_front (
    .clk_i, .rst_ni,
    .pix_valid_i(s_axis_tvalid), .pix_ready_o(s_axis_tready),
    .pix_i(s_axis_tdata), .eof_i(s_axis_tlast),
    .px_i(px_q), .py_i(py_q), .pr_i(pr_q), .ix_i(ix_q), .ir_i(ir_q),
    .w_i(w_q), .h_i(h_q),
    .frm_valid_o(frm_valid), .frm_ready_i(frm_ready), .frm_o(frm)
  );

  srmd_back u_back (
    .clk_i, .rst_ni,
    .frm_valid_i(frm_valid), .frm_ready_o(frm_ready), .frm_i(frm),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {5'd0, res};

endmodule

FILE: rtl/srmd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmd_front
// Region classification and per-region accumulation, one pixel per cycle unless full.
// ----------------------------------------------------------------------------
module srmd_front import srmd_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight,
  parameter int unsigned FracBits  = DefFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pix_valid_i,
  output logic               pix_ready_o,
  input  logic [7:0]         pix_i,
  input  logic               eof_i,
  input  logic [15:0]        px_i,
  input  logic [15:0]        py_i,
  input  logic [14:0]        pr_i,
  input  logic [15:0]        ix_i,
  input  logic [14:0]        ir_i,
  input  logic [12:0]        w_i,
  input  logic [12:0]        h_i,
  output logic               frm_valid_o,
  input  logic               frm_ready_i,
  output frame_t             frm_o
);

  localparam int unsigned PosW = 12;

  logic [PosW-1:0]      col_q, col_d, row_q, row_d;
  logic [3:0][SumW-1:0] sum_q, sum_d;
  logic [3:0][CntW-1:0] cnt_q, cnt_d;
  logic                 full_q, full_d;
  frame_t               frm_q, frm_d;

  // bounds are computed on 20 bit signed values
  function automatic logic [13:0] to_bound(input logic signed [19:0] v,
                                           input int unsigned fb,
                                           input logic [13:0] lim);
    logic [19:0] p;
    begin
      p = 20'(v) >> fb;
      if (v <= 0) to_bound = '0;
      else if (p > 20'(lim)) to_bound = lim;
      else to_bound = p[13:0];
    end
  endfunction

  logic [13:0] w, h;
  logic signed [19:0] spx, spy, spr, sir;
  logic [13:0] lx0, lx1, rx0, rx1, uy0, my, ly1;
  logic [13:0] c, r;
  logic in_l, in_r, in_u, in_d, acc;

  assign pix_ready_o = !full_q;
  assign acc = pix_valid_i && pix_ready_o;

  always_comb begin
    if (w_i == '0) w = 14'd1;
    else if (14'(w_i) > 14'(MaxWidth)) w = 14'(MaxWidth);
    else w = 14'(w_i);
    if (h_i == '0) h = 14'd1;
    else if (14'(h_i) > 14'(MaxHeight)) h = 14'(MaxHeight);
    else h = 14'(h_i);
    spx = 20'(px_i); spy = 20'(py_i); spr = 20'(pr_i); sir = 20'(ir_i);
    lx0 = to_bound(spx - spr - (sir <<< 1), FracBits, w);
    lx1 = to_bound(spx - spr - sir, FracBits, w);
    rx0 = to_bound(spx + spr + sir, FracBits, w);
    rx1 = to_bound(spx + spr + (sir <<< 1), FracBits, w);
    uy0 = to_bound((spy <<< 1) - sir, FracBits + 1, h);
    my  = to_bound(spy, FracBits, h);
    ly1 = to_bound((spy <<< 1) + sir, FracBits + 1, h);
    c = 14'(col_q);
    r = 14'(row_q);
    in_l = (c >= lx0) && (c < lx1);
    in_r = (c >= rx0) && (c < rx1);
    in_u = (r >= uy0) && (r < my);
    in_d = (r >= my) && (r < ly1);
  end

  always_comb begin
    col_d = col_q; row_d = row_q; sum_d = sum_q; cnt_d = cnt_q;
    full_d = full_q; frm_d = frm_q;
    if (full_q && frm_ready_i) full_d = 1'b0;
    if (acc) begin
      if (in_u || in_d) begin
        if (in_l) begin
          sum_d[in_d ? 2 : 0] = sum_q[in_d ? 2 : 0] + SumW'(pix_i);
          cnt_d[in_d ? 2 : 0] = cnt_q[in_d ? 2 : 0] + 1'b1;
        end
        if (in_r) begin
          sum_d[in_d ? 3 : 1] = sum_q[in_d ? 3 : 1] + SumW'(pix_i);
          cnt_d[in_d ? 3 : 1] = cnt_q[in_d ? 3 : 1] + 1'b1;
        end
      end
      if (c + 14'd1 >= w) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
      if (eof_i) begin
        frm_d.sums  = sum_d;
        frm_d.cnts  = cnt_d;
        frm_d.shift = 17'(px_i) - 17'(ix_i);
        full_d = 1'b1;
        col_d = '0; row_d = '0; sum_d = '0; cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; sum_q <= '0; cnt_q <= '0; full_q <= 1'b0;
    end else begin
      col_q <= col_d; row_q <= row_d; sum_q <= sum_d; cnt_q <= cnt_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frm_q <= frm_d;
  end

  assign frm_valid_o = full_q;
  assign frm_o = frm_q;

endmodule

FILE: rtl/srmd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmd_back
// With no region empty: four restoring divisions on a shared unit, then min of means and difference.
// ----------------------------------------------------------------------------
module srmd_back import srmd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               frm_valid_i,
  output logic               frm_ready_o,
  input  frame_t             frm_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [34:0]        res_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;
  localparam int unsigned NumW = SumW + 8;
  localparam int unsigned BitCntW = $clog2(NumW);

  logic [1:0] st_q, st_d;
  frame_t f_q, f_d;
  logic [1:0] k_q, k_d;
  logic [BitCntW-1:0] b_q, b_d;
  logic [NumW-1:0] num_q, num_d;
  logic [CntW:0] rem_q, rem_d;
  logic [3:0][QuoW-1:0] mean_q, mean_d;
  logic [34:0] res_q, res_d;
  logic [CntW:0] trial;
  logic empty;
  logic [QuoW-1:0] lm, rm;

  assign empty = (f_q.cnts[0] == '0) || (f_q.cnts[1] == '0) ||
                 (f_q.cnts[2] == '0) || (f_q.cnts[3] == '0);
  assign trial = {rem_q[CntW-1:0], num_q[NumW-1]};

  always_comb begin
    st_d = st_q; f_d = f_q; k_d = k_q; b_d = b_q; num_d = num_q;
    rem_d = rem_q; mean_d = mean_q; res_d = res_q;
    lm = (mean_q[0] < mean_q[2]) ? mean_q[0] : mean_q[2];
    rm = (mean_q[1] < mean_q[3]) ? mean_q[1] : mean_q[3];
    unique case (st_q)
      StIdle: if (frm_valid_i) begin
        f_d = frm_i; k_d = '0; b_d = '0; rem_d = '0;
        num_d = {frm_i.sums[0], 8'd0};
        st_d = StDiv;
      end
      StDiv: begin
        if (empty) begin
          res_d = {1'b1, f_q.shift, 17'd0};
          st_d = StOut;
        end else begin
          num_d = {num_q[NumW-2:0], 1'b0};
          if (trial >= {1'b0, f_q.cnts[k_q]}) begin
            rem_d = trial - {1'b0, f_q.cnts[k_q]};
            num_d[0] = 1'b1;
          end else begin
            rem_d = trial;
          end
          b_d = b_q + 1'b1;
          if (b_q == BitCntW'(NumW - 1)) begin
            mean_d[k_q] = num_d[QuoW-1:0];
            b_d = '0; rem_d = '0; k_d = k_q + 1'b1;
            num_d = {f_q.sums[k_q + 2'd1], 8'd0};
            if (k_q == 2'd3) st_d = StOut;
          end
        end
      end
      StOut: if (res_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
    if (st_q == StDiv && !empty && st_d == StOut) begin
      lm = (mean_d[0] < mean_d[2]) ? mean_d[0] : mean_d[2];
      rm = (mean_d[1] < mean_d[3]) ? mean_d[1] : mean_d[3];
      res_d = {1'b0, f_q.shift, lm - rm};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    f_q <= f_d; k_q <= k_d; b_q <= b_d; num_q <= num_d; rem_q <= rem_d;
    mean_q <= mean_d; res_q <= res_d;
  end

  assign frm_ready_o = (st_q == StIdle);
  assign res_valid_o = (st_q == StOut);
  assign res_o = res_q;

endmodule

FILE: rtl/srmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmd_checker
// Port level checks of the side region mean difference block.
// ----------------------------------------------------------------------------
module srmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
    else $error("pad bits set");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[16:0] == 17'd0)
    else $error("difference nonzero on empty region");

  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result after reset");

  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({m_axis_tvalid, s_axis_tready}))
    else $error("handshake output unknown");

endmodule

bind side_region_mean_difference srmd_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Frame-level check of side_region_mean_difference.
// ----------------------------------------------------------------------------
// Pixel frames are pushed through the stream input while geometry and image
// size are reprogrammed mostly between frames. A behavioral model tracks the raster
// position and the four side-region accumulators for every accepted pixel and
// builds the expected result on each end-of-frame pixel. Each returned result
// is compared field by field. Both stream sides idle at random, and once the
// output is held off long enough for the block to back up its input.
// ----------------------------------------------------------------------------
module tb_top;
  import srmd_pkg::*;

  localparam int ImgMax     = 4096;
  localparam int SettleCyc  = 400;
  localparam int HoldCyc    = 2500;
  localparam int TargetPix  = 1450;

  typedef struct {
    logic [7:0] pix;
    logic       eof;
  } pixel_t;

  typedef struct {
    logic signed [16:0] diff;
    logic signed [16:0] shift;
    logic               status;
  } frame_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [7:0]         s_data = '0;
  logic               s_last = 1'b0;
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [39:0]        m_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  side_region_mean_difference uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // model state
  bit [15:0] geo_px, geo_py, geo_ix;
  bit [14:0] geo_pr, geo_ir;
  bit [12:0] img_w = 13'd640, img_h = 13'd480;
  bit [11:0] col_pos, row_pos;
  bit [31:0] acc_sum [4];
  bit [23:0] acc_cnt [4];

  pixel_t     pixel_q [$];
  frame_res_t frame_result_q [$];

  int err_count, pix_sent, frames_seen, empty_seen, cfg_writes;
  int stall_pct, idle_on;
  bit hold_req, hold_taken;
  int hold_left, burst_left, gap_left;

  function automatic longint clip_bound(longint v, int fb, longint lim);
    longint p;
    if (v <= 0) return 0;
    p = v >>> fb;
    return (p > lim) ? lim : p;
  endfunction

  function automatic longint eff_dim(bit [12:0] v);
    if (v == 0) return 1;
    if (v > ImgMax) return ImgMax;
    return longint'(v);
  endfunction

  function automatic longint region_mean(int k);
    longint unsigned s;
    s = longint'(acc_sum[k]) << 8;
    return longint'(s / longint'(acc_cnt[k]));
  endfunction

  task automatic add_to_region(int k, bit [7:0] pix);
    acc_sum[k] += pix;
    acc_cnt[k] += 1;
  endtask

  // one accepted pixel through the model
  task automatic track_pixel(bit [7:0] pix, bit eof);
    longint w, h, px, py, pr, ir, lx0, lx1, rx0, rx1, uy0, my, ly1, c, r;
    longint lu, ru, ll, rl, lm, rm;
    int side, half;
    frame_res_t res;
    w = eff_dim(img_w);  h = eff_dim(img_h);
    px = geo_px;  py = geo_py;  pr = geo_pr;  ir = geo_ir;
    c = col_pos;  r = row_pos;
    side = -1;  half = -1;
    lx0 = clip_bound(px - pr - 2 * ir, 4, w);
    lx1 = clip_bound(px - pr - ir, 4, w);
    rx0 = clip_bound(px + pr + ir, 4, w);
    rx1 = clip_bound(px + pr + 2 * ir, 4, w);
    // half iris radius: one extra fraction bit
    uy0 = clip_bound(2 * py - ir, 5, h);
    my  = clip_bound(py, 4, h);
    ly1 = clip_bound(2 * py + ir, 5, h);
    if (c >= lx0 && c < lx1) side = 0;
    else if (c >= rx0 && c < rx1) side = 1;
    if (r >= uy0 && r < my) half = 0;
    else if (r >= my && r < ly1) half = 1;
    if (side >= 0 && half >= 0) add_to_region(half * 2 + side, pix);
    // overlapping left and right rectangles: pixel counts on both sides
    if (side == 0 && c >= rx0 && c < rx1 && half >= 0) add_to_region(half * 2 + 1, pix);
    if (c + 1 >= w) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    if (eof) begin
      res.shift  = 17'(longint'(geo_px) - longint'(geo_ix));
      res.status = 1'b0;
      res.diff   = '0;
      for (int k = 0; k < 4; k++) if (acc_cnt[k] == 0) res.status = 1'b1;
      if (!res.status) begin
        lu = region_mean(0);  ru = region_mean(1);
        ll = region_mean(2);  rl = region_mean(3);
        lm = (lu < ll) ? lu : ll;
        rm = (ru < rl) ? ru : rl;
        res.diff = 17'(lm - rm);
      end
      frame_result_q.push_back(res);
      col_pos = '0;
      row_pos = '0;
      for (int k = 0; k < 4; k++) begin
        acc_sum[k] = '0;
        acc_cnt[k] = '0;
      end
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // pixel sender: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t it;
    logic   nv;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_last  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!(s_valid && !s_ready)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pixel_q.size() > 0) begin
        it = pixel_q.pop_front();
        nv = 1'b1;
        s_data <= it.pix;
        s_last <= it.eof;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = idle_on ? $urandom_range(1, 6) : 0;
        end
      end
      s_valid <= nv;
    end
  end

  // result receiver: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
      hold_left = 0;
      hold_taken = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldCyc;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: model update on input and config, check on output
  always @(posedge clk_i) begin
    frame_res_t want;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          RegPupilX: geo_px = cfg_data;
          RegPupilY: geo_py = cfg_data;
          RegPupilR: geo_pr = cfg_data[14:0];
          RegIrisX:  geo_ix = cfg_data;
          RegIrisR:  geo_ir = cfg_data[14:0];
          RegWidth:  img_w  = cfg_data[12:0];
          RegHeight: img_h  = cfg_data[12:0];
          default: ;
        endcase
      end
      if (s_valid && s_ready) begin
        pix_sent++;
        track_pixel(s_data, s_last);
      end
      if (m_valid && m_ready) begin
        if (frame_result_q.size() == 0) begin
          report_mismatch("result with no frame pending", 1, 0);
        end else begin
          want = frame_result_q.pop_front();
          frames_seen++;
          if (m_data[34]) empty_seen++;
          if (m_data[16:0] !== want.diff)
            report_mismatch("eyelid_difference", $signed(m_data[16:0]), want.diff);
          if (m_data[33:17] !== want.shift)
            report_mismatch("horizontal_shift", $signed(m_data[33:17]), want.shift);
          if (m_data[34] !== want.status)
            report_mismatch("status", m_data[34], want.status);
        end
      end
    end
  end

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, int val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(int w, int h, int px, int py, int pr, int ix, int ir);
    cfg_write(RegWidth, w);
    cfg_write(RegHeight, h);
    cfg_write(RegPupilX, px);
    cfg_write(RegPupilY, py);
    cfg_write(RegPupilR, pr);
    cfg_write(RegIrisX, ix);
    cfg_write(RegIrisR, ir);
  endtask

  // style 0 random, 1 extremes only, 2 flat value
  task automatic queue_frame(int len, bit close_frame, int style);
    pixel_t it;
    logic [7:0] flat;
    flat = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      case (style)
        1:       it.pix = $urandom_range(0, 1) ? 8'hff : 8'h00;
        2:       it.pix = flat;
        default: it.pix = $urandom_range(0, 255);
      endcase
      it.eof = close_frame && (i == len - 1);
      pixel_q.push_back(it);
    end
  endtask

  task automatic drain;
    while (pixel_q.size() > 0 || s_valid || frame_result_q.size() > 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  initial begin
    int w, h, nfr, len, span, budget;
    bit pressure_done;
    pressure_done = 1'b0;
    stall_pct = 0;
    idle_on = 0;
    hold_req = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // reset geometry: every region empty
    queue_frame(3, 1'b1, 1);
    drain();
    // 8x3 image, all four regions populated, negative shift
    set_geometry(8, 3, 64, 16, 0, 200, 32);
    queue_frame(24, 1'b1, 1);
    drain();
    // extreme registers, width above the limit and zero height
    set_geometry(8191, 0, 65535, 65535, 32767, 0, 32767);
    queue_frame(2, 1'b1, 1);
    drain();
    set_geometry(4096, 1, 0, 0, 0, 65535, 0);
    queue_frame(1, 1'b1, 2);
    drain();

    while (pix_sent < TargetPix) begin
      idle_on   = $urandom_range(0, 2) != 0;
      stall_pct = idle_on ? $urandom_range(10, 70) : 0;
      case ($urandom_range(0, 9))
        0:       begin w = $urandom_range(0, 8191); h = $urandom_range(0, 3); end
        1:       begin w = $urandom_range(1, 4); h = $urandom_range(20, 60); end
        default: begin w = $urandom_range(3, 24); h = $urandom_range(2, 14); end
      endcase
      span = (w == 0) ? 1 : ((w > ImgMax) ? ImgMax : w);
      if ($urandom_range(0, 7) == 0)
        set_geometry(w, h, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 32767), $urandom_range(0, 65535),
                     $urandom_range(0, 32767));
      else
        set_geometry(w, h, $urandom_range(0, span * 16 + 15), $urandom_range(0, h * 16 + 15),
                     $urandom_range(0, span * 3), $urandom_range(0, span * 16 + 15),
                     $urandom_range(0, span * 5 + 8));
      if (!pressure_done && pix_sent > 600) begin
        // receiver held off while short frames keep coming
        pressure_done = 1'b1;
        idle_on = 0;
        @(posedge clk_i);
        hold_req <= 1'b1;
        for (int f = 0; f < 6; f++) queue_frame($urandom_range(4, 12), 1'b1, 0);
        drain();
        continue;
      end
      // keep the total pixel count near the target
      budget = TargetPix - pix_sent;
      nfr = $urandom_range(1, 4);
      for (int f = 0; f < nfr; f++) begin
        len = span * ((h == 0) ? 1 : h);
        if (len > 300 || $urandom_range(0, 4) == 0) len = $urandom_range(1, 300);
        if (len > budget) len = (budget > 0) ? budget : 1;
        budget -= len;
        queue_frame(len, 1'b1, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
      end
      // sometimes leave a frame open across the next reprogramming
      if ($urandom_range(0, 5) == 0) queue_frame($urandom_range(1, 40), 1'b0, 0);
      drain();
    end
    queue_frame($urandom_range(1, 20), 1'b1, 0);
    drain();

    $display("covered %0d pixels in %0d frames (%0d with an empty region), %0d register writes",
             pix_sent, frames_seen, empty_seen, cfg_writes);
    if (err_count == 0 && frame_result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
rtl/srmd_pkg.sv
rtl/srmd_front.sv
rtl/srmd_back.sv
rtl/side_region_mean_difference.sv
rtl/srmd_checker.sv
sim/tb_top.sv
